### hw/rtl/les_pkg.sv
// Shared types and constants for the Lorenz Euler step block.
// Used by les_seq, les_mul and lorenz_euler_step_top; no dependencies.
package les_pkg;

    // fixed point formats
    localparam int Q_W     = 32;            // state and load fields, signed Q8.24
    localparam int FRAC_W  = 24;            // fraction bits
    localparam int DT_W    = 25;            // step size, unsigned Q1.24
    localparam int GAIN_W  = 31;            // sigma, rho, beta, unsigned Q7.24
    localparam int OPND_W  = 33;            // multiplier operands, signed
    localparam int PROD_W  = 2 * OPND_W;    // full product
    localparam int DER_W   = 44;            // derivative accumulators, signed Q.24
    localparam int HI_W    = DER_W - FRAC_W; // integer part of a derivative
    localparam int ACC_W   = 48;            // new state accumulators before clipping

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE  = 3'd0,
        CFG_SIGMA_GAIN = 3'd1,
        CFG_RHO_GAIN   = 3'd2,
        CFG_BETA_GAIN  = 3'd3
    } t_cfg_idx;

    localparam logic [DT_W-1:0]   RST_STEP_SIZE  = 25'd167772;
    localparam logic [GAIN_W-1:0] RST_SIGMA_GAIN = 31'd167772160;
    localparam logic [GAIN_W-1:0] RST_RHO_GAIN   = 31'd469762048;
    localparam logic [GAIN_W-1:0] RST_BETA_GAIN  = 31'd44739243;

    // multiply schedule, issued in this order
    localparam int OP_W = 4;
    typedef enum logic [OP_W-1:0] {
        OP_SXY = 4'd0,   // sigma * (y - x)
        OP_RX  = 4'd1,   // rho * x
        OP_XZ  = 4'd2,   // x * z
        OP_XY  = 4'd3,   // x * y
        OP_BZ  = 4'd4,   // beta * z
        OP_HX  = 4'd5,   // integer part of dx times dt
        OP_LX  = 4'd6,   // fraction of dx times dt
        OP_HY  = 4'd7,
        OP_LY  = 4'd8,
        OP_HZ  = 4'd9,
        OP_LZ  = 4'd10
    } t_op;
    localparam t_op OP_LAST = OP_LZ;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_RUN   = 2'd1,
        S_DRAIN = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    // sequencer to datapath control
    typedef struct packed {
        logic issue;   // start a product this cycle
        t_op  op;      // which product
        logic busy;    // a request is in progress
        logic done;    // result goes to the output register this cycle
    } t_ctl;

    // clipped component
    typedef struct packed {
        logic                 sat;
        logic signed [Q_W-1:0] val;
    } t_clip;

endpackage

### hw/rtl/les_seq.sv
// Sequencer for the Lorenz Euler step: walks the multiply schedule.
// Depends on les_pkg.
module les_seq
    import les_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,     // request taken this cycle
    input  logic i_kind_step,  // taken request is an Euler step
    input  logic i_out_free,   // output register can take a result
    output t_ctl o_ctl
);

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_cnt, n_cnt;

    // state and op counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = i_kind_step ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + OP_W'(1);
                if (r_cnt == OP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_ctl.issue = (r_state == S_RUN);
        o_ctl.op    = t_op'(r_cnt);
        o_ctl.busy  = (r_state != S_IDLE);
        o_ctl.done  = (r_state == S_DONE) && i_out_free;
    end

    // requests only start from idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> (r_state == S_IDLE))
        else $error("request taken while sequencer busy");

    // last product is followed by the drain cycle
    a_run_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == OP_LAST) |=> (r_state == S_DRAIN))
        else $error("schedule did not end after last product");

    // a delivered result frees the sequencer
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.done |=> (r_state == S_IDLE))
        else $error("sequencer stuck after result");

endmodule

### hw/rtl/les_mul.sv
// Shared multiply unit: operand select per op code and a registered product.
// Depends on les_pkg.
module les_mul
    import les_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_op                      i_op,
    input  logic signed [Q_W-1:0]    i_x,
    input  logic signed [Q_W-1:0]    i_y,
    input  logic signed [Q_W-1:0]    i_z,
    input  logic signed [DER_W-1:0]  i_dx,
    input  logic signed [DER_W-1:0]  i_dy,
    input  logic signed [DER_W-1:0]  i_dz,
    input  logic [DT_W-1:0]          i_dt,
    input  logic [GAIN_W-1:0]        i_sigma,
    input  logic [GAIN_W-1:0]        i_rho,
    input  logic [GAIN_W-1:0]        i_beta,
    output logic signed [PROD_W-1:0] o_prod,
    output t_op                      o_op,
    output logic                     o_vld
);

    logic signed [OPND_W-1:0] w_a, w_b;
    logic signed [OPND_W-1:0] w_x, w_y, w_z, w_dt, w_hi, w_lo;
    logic signed [DER_W-1:0]  w_d;

    // sign and zero extension of the sources
    assign w_x  = {{(OPND_W-Q_W){i_x[Q_W-1]}}, i_x};
    assign w_y  = {{(OPND_W-Q_W){i_y[Q_W-1]}}, i_y};
    assign w_z  = {{(OPND_W-Q_W){i_z[Q_W-1]}}, i_z};
    assign w_dt = {{(OPND_W-DT_W){1'b0}}, i_dt};

    // derivative split into floor(d / 2^24) and the fraction left over
    always_comb begin
        case (i_op)
            OP_HY, OP_LY: w_d = i_dy;
            OP_HZ, OP_LZ: w_d = i_dz;
            default:      w_d = i_dx;
        endcase
    end
    assign w_hi = {{(OPND_W-HI_W){w_d[DER_W-1]}}, w_d[DER_W-1:FRAC_W]};
    assign w_lo = {{(OPND_W-FRAC_W){1'b0}}, w_d[FRAC_W-1:0]};

    // operand select
    always_comb begin
        case (i_op)
            OP_SXY: begin
                w_a = {{(OPND_W-GAIN_W){1'b0}}, i_sigma};
                w_b = w_y - w_x;
            end
            OP_RX: begin
                w_a = {{(OPND_W-GAIN_W){1'b0}}, i_rho};
                w_b = w_x;
            end
            OP_XZ: begin
                w_a = w_x;
                w_b = w_z;
            end
            OP_XY: begin
                w_a = w_x;
                w_b = w_y;
            end
            OP_BZ: begin
                w_a = {{(OPND_W-GAIN_W){1'b0}}, i_beta};
                w_b = w_z;
            end
            OP_HX, OP_HY, OP_HZ: begin
                w_a = w_hi;
                w_b = w_dt;
            end
            OP_LX, OP_LY, OP_LZ: begin
                w_a = w_lo;
                w_b = w_dt;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // product register, tagged with its op
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod <= PROD_W'(w_a) * PROD_W'(w_b);
            o_op   <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_en;
        end
    end

endmodule

### hw/rtl/lorenz_euler_step_top.sv
// Lorenz system, one explicit Euler step per step request or a state load, signed Q8.24 state.
// Depends on les_pkg, les_seq and les_mul.
//
//   channel   direction  handshake              payload
//   request   in         i_valid / o_stall      i_kind, i_load_x, i_load_y, i_load_z
//   result    out        o_valid / i_stall      o_out_x, o_out_y, o_out_z, o_saturated
//   config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// A step result is registered after eleven products on one 33x33 multiplier, a drain
// state for the last product and a done state that clips and writes the result out.
// A load result goes straight to the done state and is registered from there.
// o_stall drops as the result is registered, together with o_valid rising, so the next
// request can be taken while that result waits at the output.
// Reset zeroes the state and loads the default step size and gains.
// A finished result stalled at the output holds the sequencer until the register frees.
module lorenz_euler_step_top
    import les_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_kind,
    input  logic signed [Q_W-1:0]  i_load_x,
    input  logic signed [Q_W-1:0]  i_load_y,
    input  logic signed [Q_W-1:0]  i_load_z,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [Q_W-1:0]  o_out_x,
    output logic signed [Q_W-1:0]  o_out_y,
    output logic signed [Q_W-1:0]  o_out_z,
    output logic                   o_saturated,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_ctl                      w_ctl;
    logic                      w_accept, w_out_free;
    logic [DT_W-1:0]           r_dt;
    logic [GAIN_W-1:0]         r_sigma, r_rho, r_beta;
    logic signed [Q_W-1:0]     r_x, r_y, r_z;
    logic signed [DER_W-1:0]   r_dx, r_dy, r_dz;
    logic signed [ACC_W-1:0]   r_nx, r_ny, r_nz;
    logic signed [PROD_W-1:0]  w_prod, w_shift;
    logic signed [DER_W-1:0]   w_sh_d;
    logic signed [ACC_W-1:0]   w_sh_a, w_prod_a;
    t_op                       w_acc_op;
    logic                      w_acc_vld;
    t_clip                     w_cx, w_cy, w_cz;

    function automatic t_clip f_clip(input logic signed [ACC_W-1:0] v);
        t_clip c;
        c.sat = !((&v[ACC_W-1:Q_W-1]) || !(|v[ACC_W-1:Q_W-1]));
        if (!c.sat) begin
            c.val = v[Q_W-1:0];
        end else if (v[ACC_W-1]) begin
            c.val = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            c.val = {1'b0, {(Q_W-1){1'b1}}};
        end
        return c;
    endfunction

    // handshakes
    assign o_stall    = w_ctl.busy;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !o_valid || !i_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= RST_STEP_SIZE;
            r_sigma <= RST_SIGMA_GAIN;
            r_rho   <= RST_RHO_GAIN;
            r_beta  <= RST_BETA_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_SIZE:  r_dt    <= i_cfg_data[DT_W-1:0];
                CFG_SIGMA_GAIN: r_sigma <= i_cfg_data[GAIN_W-1:0];
                CFG_RHO_GAIN:   r_rho   <= i_cfg_data[GAIN_W-1:0];
                CFG_BETA_GAIN:  r_beta  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    les_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind_step (i_kind),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl)
    );

    // shared multiplier
    les_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ctl.issue),
        .i_op    (w_ctl.op),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_z     (r_z),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_dz    (r_dz),
        .i_dt    (r_dt),
        .i_sigma (r_sigma),
        .i_rho   (r_rho),
        .i_beta  (r_beta),
        .o_prod  (w_prod),
        .o_op    (w_acc_op),
        .o_vld   (w_acc_vld)
    );

    // product brought back to Q.24, floor rounding
    assign w_shift  = w_prod >>> FRAC_W;
    assign w_sh_d   = signed'(w_shift[DER_W-1:0]);
    assign w_sh_a   = signed'(w_shift[ACC_W-1:0]);
    assign w_prod_a = signed'(w_prod[ACC_W-1:0]);

    // derivative and new state accumulators
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dx <= '0;
            r_dz <= '0;
            r_dy <= -{{(DER_W-Q_W){r_y[Q_W-1]}}, r_y};
            if (i_kind) begin
                r_nx <= {{(ACC_W-Q_W){r_x[Q_W-1]}}, r_x};
                r_ny <= {{(ACC_W-Q_W){r_y[Q_W-1]}}, r_y};
                r_nz <= {{(ACC_W-Q_W){r_z[Q_W-1]}}, r_z};
            end else begin
                r_nx <= {{(ACC_W-Q_W){i_load_x[Q_W-1]}}, i_load_x};
                r_ny <= {{(ACC_W-Q_W){i_load_y[Q_W-1]}}, i_load_y};
                r_nz <= {{(ACC_W-Q_W){i_load_z[Q_W-1]}}, i_load_z};
            end
        end else if (w_acc_vld) begin
            case (w_acc_op)
                OP_SXY: r_dx <= w_sh_d;
                OP_RX:  r_dy <= r_dy + w_sh_d;
                OP_XZ:  r_dy <= r_dy - w_sh_d;
                OP_XY:  r_dz <= r_dz + w_sh_d;
                OP_BZ:  r_dz <= r_dz - w_sh_d;
                OP_HX:  r_nx <= r_nx + w_prod_a;
                OP_LX:  r_nx <= r_nx + w_sh_a;
                OP_HY:  r_ny <= r_ny + w_prod_a;
                OP_LY:  r_ny <= r_ny + w_sh_a;
                OP_HZ:  r_nz <= r_nz + w_prod_a;
                OP_LZ:  r_nz <= r_nz + w_sh_a;
                default: ;
            endcase
        end
    end

    // clip to the Q8.24 range
    assign w_cx = f_clip(r_nx);
    assign w_cy = f_clip(r_ny);
    assign w_cz = f_clip(r_nz);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else if (w_ctl.done) begin
            r_x <= w_cx.val;
            r_y <= w_cy.val;
            r_z <= w_cz.val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_ctl.done) begin
            o_out_x     <= w_cx.val;
            o_out_y     <= w_cy.val;
            o_out_z     <= w_cz.val;
            o_saturated <= w_cx.sat || w_cy.sat || w_cz.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_ctl.done) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    // a finished result always lands in the output register
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.done |=> o_valid)
        else $error("result lost at output register");

endmodule

### test/lorenz_euler_step_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for lorenz_euler_step_top: state loads and Euler steps
// are checked against a fixed-point Lorenz predictor kept in a scoreboard class.
// Depends on les_pkg and the lorenz_euler_step_top RTL.
module lorenz_euler_step_top_test;
    import les_pkg::*;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;
    localparam int FRACTION      = 24;
    localparam int IDLE_PCT      = 13;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;

    // Q8.24 values
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0100_0000;
    localparam logic signed [Q_W-1:0] Q_NEG_LSB = -32'sd1;

    // classic Lorenz settings, also the values after reset
    localparam logic [CFG_DATA_W-1:0] CLASSIC_DT    = 31'd167772;
    localparam logic [CFG_DATA_W-1:0] CLASSIC_SIGMA = 31'd167772160;
    localparam logic [CFG_DATA_W-1:0] CLASSIC_RHO   = 31'd469762048;
    localparam logic [CFG_DATA_W-1:0] CLASSIC_BETA  = 31'd44739243;

    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
        logic                  sat;
    } t_lorenz_point;

    // tracks the Lorenz state and the results still owed by the block
    class t_lorenz_tracker;
        logic [DT_W-1:0]       dt;
        logic [GAIN_W-1:0]     sigma;
        logic [GAIN_W-1:0]     rho;
        logic [GAIN_W-1:0]     beta;
        logic signed [Q_W-1:0] cur_x;
        logic signed [Q_W-1:0] cur_y;
        logic signed [Q_W-1:0] cur_z;
        logic                  step_clipped;
        t_lorenz_point         pending_states[$];
        int                    mismatches;
        int                    loads;
        int                    steps;
        int                    clipped;

        function new();
            dt = CLASSIC_DT[DT_W-1:0];
            sigma = CLASSIC_SIGMA[GAIN_W-1:0];
            rho = CLASSIC_RHO[GAIN_W-1:0];
            beta = CLASSIC_BETA[GAIN_W-1:0];
            cur_x = '0;
            cur_y = '0;
            cur_z = '0;
            step_clipped = 1'b0;
            mismatches = 0;
            loads = 0;
            steps = 0;
            clipped = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STEP_SIZE:  dt = data[DT_W-1:0];
                CFG_SIGMA_GAIN: sigma = data[GAIN_W-1:0];
                CFG_RHO_GAIN:   rho = data[GAIN_W-1:0];
                CFG_BETA_GAIN:  beta = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // limit to the Q8.24 range and remember any clipping
        function logic signed [Q_W-1:0] clamp(logic signed [127:0] v);
            logic signed [127:0] hi_lim;
            logic signed [127:0] lo_lim;
            hi_lim = 128'(Q_MAX);
            lo_lim = 128'(Q_MIN);
            if (v > hi_lim) begin
                step_clipped = 1'b1;
                return Q_MAX;
            end
            if (v < lo_lim) begin
                step_clipped = 1'b1;
                return Q_MIN;
            end
            return v[Q_W-1:0];
        endfunction

        // one explicit Euler step, products exact and floored back to Q8.24
        function void euler_advance();
            logic signed [127:0] wx, wy, wz, wdt, wsg, wrh, wbt, dx, dy, dz;
            wx = 128'(cur_x);
            wy = 128'(cur_y);
            wz = 128'(cur_z);
            wdt = 128'(dt);
            wsg = 128'(sigma);
            wrh = 128'(rho);
            wbt = 128'(beta);
            dx = (wsg * (wy - wx)) >>> FRACTION;
            dy = ((wrh * wx) >>> FRACTION) - wy - ((wx * wz) >>> FRACTION);
            dz = ((wx * wy) >>> FRACTION) - ((wbt * wz) >>> FRACTION);
            cur_x = clamp(wx + ((dx * wdt) >>> FRACTION));
            cur_y = clamp(wy + ((dy * wdt) >>> FRACTION));
            cur_z = clamp(wz + ((dz * wdt) >>> FRACTION));
        endfunction

        function void note_request(logic kind, logic signed [Q_W-1:0] lx,
                                   logic signed [Q_W-1:0] ly, logic signed [Q_W-1:0] lz);
            t_lorenz_point res;
            step_clipped = 1'b0;
            if (kind == KIND_LOAD) begin
                cur_x = lx;
                cur_y = ly;
                cur_z = lz;
                loads++;
            end else begin
                euler_advance();
                steps++;
                if (step_clipped)
                    clipped++;
            end
            res.x = cur_x;
            res.y = cur_y;
            res.z = cur_z;
            res.sat = step_clipped;
            pending_states.push_back(res);
        endfunction

        function void field_check(string name, logic [Q_W-1:0] want, logic [Q_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic signed [Q_W-1:0] ox, logic signed [Q_W-1:0] oy,
                                   logic signed [Q_W-1:0] oz, logic osat);
            t_lorenz_point want;
            if (pending_states.size() == 0) begin
                $display("%0t: unrequested result x=%h y=%h z=%h sat=%b", $time,
                         ox, oy, oz, osat);
                mismatches++;
                return;
            end
            want = pending_states.pop_front();
            field_check("out_x", want.x, ox);
            field_check("out_y", want.y, oy);
            field_check("out_z", want.z, oz);
            field_check("saturated", {31'd0, want.sat}, {31'd0, osat});
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_kind;
    logic signed [Q_W-1:0] i_load_x;
    logic signed [Q_W-1:0] i_load_y;
    logic signed [Q_W-1:0] i_load_z;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [Q_W-1:0] o_out_x;
    logic signed [Q_W-1:0] o_out_y;
    logic signed [Q_W-1:0] o_out_z;
    logic                  o_saturated;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_lorenz_tracker tracker;
    bit              calm = 1'b0;
    bit              hold_off_req = 1'b0;
    int              cycle_count = 0;
    int              settings_seen = 1;

    lorenz_euler_step_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_load_x    (i_load_x),
        .i_load_y    (i_load_y),
        .i_load_z    (i_load_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_saturated (o_saturated),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lorenz_euler_step_top_test: errors");
            $finish;
        end
    end

    // result side: check accepted results, stall at random or for a long hold-off
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                tracker.check_result(o_out_x, o_out_y, o_out_z, o_saturated);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_request(input logic kind, input logic signed [Q_W-1:0] lx,
                                input logic signed [Q_W-1:0] ly,
                                input logic signed [Q_W-1:0] lz);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_load_x <= lx;
        i_load_y <= ly;
        i_load_z <= lz;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        tracker.note_request(kind, lx, ly, lz);
    endtask

    // stop offering, wait for every owed result, let the block go idle
    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.pending_states.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_register(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] dt, input logic [CFG_DATA_W-1:0] sg,
                             input logic [CFG_DATA_W-1:0] rh, input logic [CFG_DATA_W-1:0] bt);
        write_register(CFG_STEP_SIZE, dt);
        write_register(CFG_SIGMA_GAIN, sg);
        write_register(CFG_RHO_GAIN, rh);
        write_register(CFG_BETA_GAIN, bt);
        settings_seen++;
    endtask

    // mostly attractor-sized values, some full-range and some extremes
    function automatic logic signed [Q_W-1:0] pick_component();
        int unsigned           roll;
        logic signed [Q_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            v = $urandom_range(0, 32'd1006632960);
            v = v - 32'sd503316480;
        end else if (roll < 80) begin
            v = $urandom;
        end else begin
            case ($urandom_range(0, 4))
                0: v = Q_MAX;
                1: v = Q_MIN;
                2: v = '0;
                3: v = Q_NEG_LSB;
                default: v = Q_ONE;
            endcase
        end
        return v;
    endfunction

    // a load now and then, runs of steps between loads
    task automatic random_requests(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 12)
                send_request(KIND_LOAD, pick_component(), pick_component(), pick_component());
            else
                send_request(KIND_STEP, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin : stimulus
        tracker = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_kind <= KIND_LOAD;
        i_load_x <= '0;
        i_load_y <= '0;
        i_load_z <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_STEP_SIZE;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero state after reset, unit start, field extremes, clipping
        send_request(KIND_STEP, Q_MAX, Q_MIN, Q_MAX);
        send_request(KIND_LOAD, Q_ONE, Q_ONE, Q_ONE);
        repeat (3) send_request(KIND_STEP, '0, '0, '0);
        send_request(KIND_LOAD, Q_MAX, Q_MAX, Q_MAX);
        send_request(KIND_STEP, '0, '0, '0);
        send_request(KIND_LOAD, Q_MIN, Q_MIN, Q_MIN);
        send_request(KIND_STEP, '0, '0, '0);
        send_request(KIND_LOAD, Q_MAX, Q_MIN, Q_MIN);
        send_request(KIND_STEP, Q_MIN, Q_MAX, Q_MIN);
        send_request(KIND_LOAD, Q_MIN, Q_MAX, '0);
        send_request(KIND_STEP, '0, '0, '0);
        send_request(KIND_LOAD, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB);
        repeat (2) send_request(KIND_STEP, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB);
        send_request(KIND_LOAD, Q_ONE, '0, -Q_ONE);
        repeat (2) send_request(KIND_STEP, '0, '0, '0);
        random_requests(50);
        settle();

        // step size zero, gains at the top, plus a write to an unmapped index
        write_all('0, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        write_register(CFG_UNMAPPED, 31'h7fff_ffff);
        random_requests(45);
        settle();

        // widest step size (upper data bits dropped), gains at zero
        write_all(31'h7fff_ffff, '0, '0, '0);
        random_requests(45);
        settle();

        // unit step size with a long receiver hold-off while requests keep coming
        write_all(31'd16777216, 31'd16777216, 31'd33554432, 31'd8388608);
        hold_off_req = 1'b1;
        random_requests(60);
        settle();

        // fully random settings
        write_all(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        random_requests(60);
        settle();

        // classic Lorenz settings with no idling on either side
        write_all(CLASSIC_DT, CLASSIC_SIGMA, CLASSIC_RHO, CLASSIC_BETA);
        calm = 1'b1;
        random_requests(80);
        calm = 1'b0;
        settle();

        // random gains, small step size, another hold-off
        write_all(CFG_DATA_W'($urandom_range(0, 32'd1048576)), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        hold_off_req = 1'b1;
        random_requests(90);
        settle();

        $display("run covered %0d loads and %0d Euler steps over %0d register settings",
                 tracker.loads, tracker.steps, settings_seen);
        $display("%0d steps clipped to the Q8.24 range, %0d mismatches",
                 tracker.clipped, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_states.size() == 0)
            $display("lorenz_euler_step_top_test: clean");
        else
            $display("lorenz_euler_step_top_test: errors");
        $finish;
    end

endmodule
